FILE: design/assert_macros.svh
// assertion macros shared by the span fill design files
// needs clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define PSF_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define PSF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define PSF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/psf_pkg.sv
// shared types and constants of the polygon span fill unit
// no dependencies
package psf_pkg;

    // command codes
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_RASTER = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_RIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_BOTTOM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_COLOR  = 3'd4;

    localparam int MIN_VERTICES = 3;
    localparam int MAX_SPANS    = 32;
    localparam int SPAN_CNT_W   = 6;

    // crossing key: 18-bit signed integer part, 32-bit fraction
    localparam int FRAC_W = 32;
    localparam int INT_W  = 18;
    localparam int KEY_W  = INT_W + FRAC_W;

    // divider result: floor quotient and binary fraction of the remainder
    typedef struct packed {
        logic signed [16:0]  quo;
        logic [FRAC_W-1:0]   frac;
    } div_res_t;

endpackage

FILE: design/psf_div.sv
// bit-serial floor divider with fraction for edge crossings
// depends on psf_pkg and assert_macros.svh
`include "assert_macros.svh"

module psf_div
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [31:0]         num,
    input  logic [15:0]         den,
    input  logic                neg,
    output logic                done,
    output psf_pkg::div_res_t   res
);

    typedef enum logic [1:0] {D_IDLE, D_QUO, D_FIX, D_FRAC} dstate_t;

    dstate_t                     state_reg;
    logic [15:0]                 rem_reg;
    logic [15:0]                 sh_reg;
    logic [psf_pkg::FRAC_W-1:0]  frac_reg;
    logic signed [16:0]          quo_reg;
    logic [15:0]                 den_reg;
    logic                        neg_reg;
    logic [4:0]                  cnt_reg;
    logic                        done_reg;

    logic                        in_bit;
    logic [16:0]                 trial;
    logic                        ge;
    logic [16:0]                 diff;
    logic [15:0]                 rem_step;

    // one restoring step per cycle
    always_comb
    begin
        in_bit   = (state_reg == D_QUO) ? sh_reg[15] : 1'b0;
        trial    = {rem_reg, in_bit};
        ge       = (trial >= {1'b0, den_reg});
        diff     = trial - {1'b0, den_reg};
        rem_step = ge ? diff[15:0] : trial[15:0];
    end

    // sequencer: 16 quotient bits, sign fix, 32 fraction bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            rem_reg   <= '0;
            sh_reg    <= '0;
            frac_reg  <= '0;
            quo_reg   <= '0;
            den_reg   <= '0;
            neg_reg   <= 1'b0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        rem_reg   <= num[31:16];
                        sh_reg    <= num[15:0];
                        den_reg   <= den;
                        neg_reg   <= neg;
                        cnt_reg   <= '0;
                        state_reg <= D_QUO;
                    end
                end
                D_QUO:
                begin
                    rem_reg <= rem_step;
                    sh_reg  <= {sh_reg[14:0], ge};
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd15)
                    begin
                        state_reg <= D_FIX;
                    end
                end
                D_FIX:
                begin
                    // turn truncated magnitude into floor quotient
                    if (neg_reg && (rem_reg != '0))
                    begin
                        quo_reg <= ~$signed({1'b0, sh_reg});
                        rem_reg <= den_reg - rem_reg;
                    end
                    else if (neg_reg)
                    begin
                        quo_reg <= -$signed({1'b0, sh_reg});
                    end
                    else
                    begin
                        quo_reg <= $signed({1'b0, sh_reg});
                    end
                    cnt_reg   <= '0;
                    state_reg <= D_FRAC;
                end
                D_FRAC:
                begin
                    rem_reg  <= rem_step;
                    frac_reg <= {frac_reg[psf_pkg::FRAC_W-2:0], ge};
                    cnt_reg  <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign done     = done_reg;
    assign res.quo  = quo_reg;
    assign res.frac = frac_reg;

    `PSF_ASSERT_IMP(a_div_start_idle, start, state_reg == D_IDLE, "divider started while busy")
    `PSF_ASSERT_IMP(a_div_done_idle, done_reg, state_reg == D_IDLE, "divider done while running")

endmodule

FILE: design/polygon_scanline_span_fill_unit.sv
// Even-odd scanline polygon fill: vertex store, crossing walk, sort, span emit.
// Clear and append leave the unit idle; a rejected row gives its result the cycle after.
// A rasterize request walks every edge, runs the serial divider for each edge crossed,
// insertion-sorts each crossing into the key memory, then walks the crossing pairs to
// emit spans; spans leave one per strobe, the receiver cannot stall.
// Requests are taken only while busy is low. rst_n clears the vertex count and the
// clip registers to their defaults; the vertex and key memories are not cleared.
// depends on psf_pkg, psf_div and assert_macros.svh
`include "assert_macros.svh"

module polygon_scanline_span_fill_unit
#(
    parameter int MAX_VERTICES = 64
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         cmd,
    input  logic signed [15:0]                 coord_x,
    input  logic signed [15:0]                 coord_y,
    input  logic                               cfg_wr_en,
    input  logic [psf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [15:0]                        cfg_wdata,
    output logic                               result_strobe,
    output logic signed [15:0]                 row_y,
    output logic signed [15:0]                 span_left,
    output logic signed [15:0]                 span_right,
    output logic                               span_valid,
    output logic [7:0]                         pixel_color,
    output logic                               last
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int KW = psf_pkg::KEY_W;
    localparam int FW = psf_pkg::FRAC_W;
    localparam int IW = psf_pkg::INT_W;
    localparam int SW = psf_pkg::SPAN_CNT_W;

    typedef enum logic [3:0] {
        S_IDLE, S_VFIRST, S_ERD, S_ECHK, S_EMUL, S_DSTART, S_DWAIT,
        S_INS, S_CMP, S_ENEXT, S_PCHK, S_PRD1, S_PCALC, S_FLUSH
    } state_t;

    // configuration registers
    logic signed [15:0] clip_left_reg, clip_top_reg, clip_right_reg, clip_bottom_reg;
    logic [7:0]         fill_color_reg;

    // memories
    logic signed [15:0]   vx_mem [MAX_VERTICES];
    logic signed [15:0]   vy_mem [MAX_VERTICES];
    logic signed [KW-1:0] key_mem [MAX_VERTICES];

    logic signed [15:0]   vx_rd_reg, vy_rd_reg;
    logic signed [KW-1:0] k_rd_reg;

    // control and datapath registers
    state_t               state_reg;
    logic [CW-1:0]        vcount_reg;
    logic signed [15:0]   row_reg;
    logic [CW-1:0]        i_reg;
    logic [CW-1:0]        nk_reg;
    logic [CW-1:0]        j_reg;
    logic [CW:0]          p_reg;
    logic [SW-1:0]        nspan_reg;
    logic signed [15:0]   first_x_reg, first_y_reg;
    logic signed [15:0]   prev_x_reg, prev_y_reg;
    logic signed [15:0]   cur_x_reg, cur_y_reg;
    logic [15:0]          ma_reg, mb_reg, den_reg;
    logic                 neg_reg;
    logic [31:0]          prod_reg;
    logic signed [KW-1:0] key_reg;
    logic signed [KW-1:0] ka_reg;
    logic                 have_buf_reg;
    logic signed [15:0]   buf_l_reg, buf_r_reg;

    // result registers
    logic                 strobe_reg;
    logic signed [15:0]   row_out_reg, left_out_reg, right_out_reg;
    logic                 valid_out_reg, last_out_reg;
    logic [7:0]           color_out_reg;

    // divider link
    logic                 div_start;
    logic                 div_done;
    psf_pkg::div_res_t    div_res;

    // memory ports
    logic [AW-1:0]        v_raddr;
    logic                 v_we;
    logic [AW-1:0]        k_raddr;
    logic                 k_we;
    logic [AW-1:0]        k_waddr;
    logic signed [KW-1:0] k_wdata;

    // helpers
    logic [CW-1:0]        i_inc, j_dec;
    logic [CW:0]          p_inc, p_inc2;
    logic                 has_next;
    logic signed [15:0]   cx, cy;
    logic signed [15:0]   lo_y, hi_y;
    logic                 crosses;
    logic signed [16:0]   da, db, dy;
    logic [16:0]          abs_a, abs_b, abs_dy;
    logic                 row_reject;
    logic                 k_gt;
    logic signed [IW:0]   left_c, right_c, clip_l_e, clip_r_e, left_k, right_k;
    logic                 span_ok;

    psf_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (prod_reg),
        .den   (den_reg),
        .neg   (neg_reg),
        .done  (div_done),
        .res   (div_res)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_left_reg   <= 16'sd0;
            clip_top_reg    <= 16'sd0;
            clip_right_reg  <= 16'sd639;
            clip_bottom_reg <= 16'sd479;
            fill_color_reg  <= 8'd1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                psf_pkg::CFG_CLIP_LEFT:   clip_left_reg   <= cfg_wdata;
                psf_pkg::CFG_CLIP_TOP:    clip_top_reg    <= cfg_wdata;
                psf_pkg::CFG_CLIP_RIGHT:  clip_right_reg  <= cfg_wdata;
                psf_pkg::CFG_CLIP_BOTTOM: clip_bottom_reg <= cfg_wdata;
                psf_pkg::CFG_FILL_COLOR:  fill_color_reg  <= cfg_wdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // index arithmetic, edge crossing test, row reject test and key compare
    always_comb
    begin
        i_inc    = i_reg + CW'(1);
        j_dec    = j_reg - CW'(1);
        p_inc    = p_reg + (CW+1)'(1);
        p_inc2   = p_reg + (CW+1)'(2);
        has_next = (i_inc < vcount_reg);
        cx       = has_next ? vx_rd_reg : first_x_reg;
        cy       = has_next ? vy_rd_reg : first_y_reg;
        lo_y     = (prev_y_reg < cy) ? prev_y_reg : cy;
        hi_y     = (prev_y_reg < cy) ? cy : prev_y_reg;
        crosses  = (prev_y_reg != cy) && (row_reg >= lo_y) && (row_reg < hi_y);
        da       = 17'(row_reg) - 17'(prev_y_reg);
        db       = 17'(cx) - 17'(prev_x_reg);
        dy       = 17'(cy) - 17'(prev_y_reg);
        abs_a    = da[16] ? 17'(-da) : 17'(da);
        abs_b    = db[16] ? 17'(-db) : 17'(db);
        abs_dy   = dy[16] ? 17'(-dy) : 17'(dy);
        row_reject = (vcount_reg < CW'(psf_pkg::MIN_VERTICES))
                     || (clip_right_reg < clip_left_reg)
                     || (clip_bottom_reg < clip_top_reg)
                     || (coord_y < clip_top_reg) || (coord_y > clip_bottom_reg);
        k_gt     = (k_rd_reg > key_reg);
    end

    // span of one crossing pair: ceil of left key, floor of right key, clipped
    always_comb
    begin
        left_c   = (IW+1)'($signed(ka_reg[KW-1:FW])) + (IW+1)'(ka_reg[FW-1:0] != '0);
        right_c  = (IW+1)'($signed(k_rd_reg[KW-1:FW]));
        clip_l_e = (IW+1)'(clip_left_reg);
        clip_r_e = (IW+1)'(clip_right_reg);
        left_k   = (left_c < clip_l_e) ? clip_l_e : left_c;
        right_k  = (right_c > clip_r_e) ? clip_r_e : right_c;
        span_ok  = (left_k <= right_k);
    end

    // memory addresses, write strobes and divider start
    always_comb
    begin
        v_raddr   = (state_reg == S_ERD) ? i_inc[AW-1:0] : '0;
        v_we      = (state_reg == S_IDLE) && start && (cmd == psf_pkg::CMD_APPEND)
                    && (vcount_reg < CW'(MAX_VERTICES));
        case (state_reg)
            S_INS:   k_raddr = j_dec[AW-1:0];
            S_PCHK:  k_raddr = p_reg[AW-1:0];
            S_PRD1:  k_raddr = p_inc[AW-1:0];
            default: k_raddr = '0;
        endcase
        k_we      = ((state_reg == S_INS) && (j_reg == '0)) || (state_reg == S_CMP);
        k_waddr   = j_reg[AW-1:0];
        k_wdata   = ((state_reg == S_CMP) && k_gt) ? k_rd_reg : key_reg;
        div_start = (state_reg == S_DSTART);
    end

    // vertex memory
    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            vx_mem[vcount_reg[AW-1:0]] <= coord_x;
            vy_mem[vcount_reg[AW-1:0]] <= coord_y;
        end
        vx_rd_reg <= vx_mem[v_raddr];
        vy_rd_reg <= vy_mem[v_raddr];
    end

    // crossing key memory
    always_ff @(posedge clk)
    begin
        if (k_we)
        begin
            key_mem[k_waddr] <= k_wdata;
        end
        k_rd_reg <= key_mem[k_raddr];
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vcount_reg    <= '0;
            row_reg       <= '0;
            i_reg         <= '0;
            nk_reg        <= '0;
            j_reg         <= '0;
            p_reg         <= '0;
            nspan_reg     <= '0;
            first_x_reg   <= '0;
            first_y_reg   <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            ma_reg        <= '0;
            mb_reg        <= '0;
            den_reg       <= '0;
            neg_reg       <= 1'b0;
            prod_reg      <= '0;
            key_reg       <= '0;
            ka_reg        <= '0;
            have_buf_reg  <= 1'b0;
            buf_l_reg     <= '0;
            buf_r_reg     <= '0;
            strobe_reg    <= 1'b0;
            row_out_reg   <= '0;
            left_out_reg  <= '0;
            right_out_reg <= '0;
            valid_out_reg <= 1'b0;
            last_out_reg  <= 1'b0;
            color_out_reg <= '0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        case (cmd)
                            psf_pkg::CMD_CLEAR:
                            begin
                                vcount_reg <= '0;
                            end
                            psf_pkg::CMD_APPEND:
                            begin
                                if (v_we)
                                begin
                                    vcount_reg <= vcount_reg + CW'(1);
                                end
                            end
                            psf_pkg::CMD_RASTER:
                            begin
                                row_reg <= coord_y;
                                if (row_reject)
                                begin
                                    strobe_reg    <= 1'b1;
                                    row_out_reg   <= coord_y;
                                    left_out_reg  <= '0;
                                    right_out_reg <= '0;
                                    valid_out_reg <= 1'b0;
                                    color_out_reg <= '0;
                                    last_out_reg  <= 1'b1;
                                end
                                else
                                begin
                                    i_reg        <= '0;
                                    nk_reg       <= '0;
                                    p_reg        <= '0;
                                    nspan_reg    <= '0;
                                    have_buf_reg <= 1'b0;
                                    state_reg    <= S_VFIRST;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_VFIRST:
                begin
                    first_x_reg <= vx_rd_reg;
                    first_y_reg <= vy_rd_reg;
                    prev_x_reg  <= vx_rd_reg;
                    prev_y_reg  <= vy_rd_reg;
                    state_reg   <= S_ERD;
                end
                S_ERD:
                begin
                    state_reg <= S_ECHK;
                end
                S_ECHK:
                begin
                    // latch edge end point and operand magnitudes
                    cur_x_reg <= cx;
                    cur_y_reg <= cy;
                    ma_reg    <= abs_a[15:0];
                    mb_reg    <= abs_b[15:0];
                    den_reg   <= abs_dy[15:0];
                    neg_reg   <= da[16] ^ db[16] ^ dy[16];
                    state_reg <= crosses ? S_EMUL : S_ENEXT;
                end
                S_EMUL:
                begin
                    prod_reg  <= ma_reg * mb_reg;
                    state_reg <= S_DSTART;
                end
                S_DSTART:
                begin
                    state_reg <= S_DWAIT;
                end
                S_DWAIT:
                begin
                    if (div_done)
                    begin
                        key_reg   <= {IW'(prev_x_reg) + IW'(div_res.quo), div_res.frac};
                        j_reg     <= nk_reg;
                        state_reg <= S_INS;
                    end
                end
                S_INS:
                begin
                    // stable insertion: shift larger keys up one slot
                    if (j_reg == '0)
                    begin
                        nk_reg    <= nk_reg + CW'(1);
                        state_reg <= S_ENEXT;
                    end
                    else
                    begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    if (k_gt)
                    begin
                        j_reg     <= j_dec;
                        state_reg <= S_INS;
                    end
                    else
                    begin
                        nk_reg    <= nk_reg + CW'(1);
                        state_reg <= S_ENEXT;
                    end
                end
                S_ENEXT:
                begin
                    prev_x_reg <= cur_x_reg;
                    prev_y_reg <= cur_y_reg;
                    i_reg      <= i_inc;
                    state_reg  <= (i_inc == vcount_reg) ? S_PCHK : S_ERD;
                end
                S_PCHK:
                begin
                    if ((p_inc < {1'b0, nk_reg}) && (nspan_reg < SW'(psf_pkg::MAX_SPANS)))
                    begin
                        state_reg <= S_PRD1;
                    end
                    else
                    begin
                        state_reg <= S_FLUSH;
                    end
                end
                S_PRD1:
                begin
                    ka_reg    <= k_rd_reg;
                    state_reg <= S_PCALC;
                end
                S_PCALC:
                begin
                    // hold one span back so the final one can carry last
                    if (span_ok)
                    begin
                        if (have_buf_reg)
                        begin
                            strobe_reg    <= 1'b1;
                            row_out_reg   <= row_reg;
                            left_out_reg  <= buf_l_reg;
                            right_out_reg <= buf_r_reg;
                            valid_out_reg <= 1'b1;
                            color_out_reg <= fill_color_reg;
                            last_out_reg  <= 1'b0;
                        end
                        buf_l_reg    <= left_k[15:0];
                        buf_r_reg    <= right_k[15:0];
                        have_buf_reg <= 1'b1;
                        nspan_reg    <= nspan_reg + SW'(1);
                    end
                    p_reg     <= p_inc2;
                    state_reg <= S_PCHK;
                end
                S_FLUSH:
                begin
                    strobe_reg    <= 1'b1;
                    row_out_reg   <= row_reg;
                    last_out_reg  <= 1'b1;
                    valid_out_reg <= have_buf_reg;
                    left_out_reg  <= have_buf_reg ? buf_l_reg : 16'sd0;
                    right_out_reg <= have_buf_reg ? buf_r_reg : 16'sd0;
                    color_out_reg <= have_buf_reg ? fill_color_reg : 8'd0;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign result_strobe = strobe_reg;
    assign row_y         = row_out_reg;
    assign span_left     = left_out_reg;
    assign span_right    = right_out_reg;
    assign span_valid    = valid_out_reg;
    assign pixel_color   = color_out_reg;
    assign last          = last_out_reg;

    `PSF_ASSERT_IMP(a_empty_is_last, strobe_reg && !valid_out_reg, last_out_reg, "empty row result without last")
    `PSF_ASSERT_IMP(a_span_order, strobe_reg && valid_out_reg, left_out_reg <= right_out_reg, "span left beyond right")
    `PSF_ASSERT_IMP(a_keys_bounded, state_reg != S_IDLE, nk_reg <= vcount_reg, "too many crossings")
    `PSF_ASSERT_NXT(a_div_wait, state_reg == S_DSTART, state_reg == S_DWAIT, "divider launch out of order")

endmodule
